FILE: design/lrk_pkg.sv
// Shared types, codes and the step microprogram of the Lorenz RK4 integrator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package lrk_pkg;

  // Input and result words.
  typedef struct packed {
    logic              req_type;
    logic signed [31:0] init_x;
    logic signed [31:0] init_y;
    logic signed [31:0] init_z;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [47:0] time_now;
    logic [15:0]        step_index;
    logic               last_step;
    logic               step_too_small;
    logic               overflow;
  } out_word_t;

  // Configuration register indexes.
  localparam logic [2:0] CFG_SIGMA = 3'd0;
  localparam logic [2:0] CFG_BETA  = 3'd1;
  localparam logic [2:0] CFG_RHO   = 3'd2;
  localparam logic [2:0] CFG_STEP  = 3'd3;
  localparam logic [2:0] CFG_START = 3'd4;
  localparam logic [2:0] CFG_RUNS  = 3'd5;

  localparam logic [0:0] REQ_LOAD = 1'b0;
  localparam logic [0:0] REQ_STEP = 1'b1;

  // Reciprocal of three scaled by 2^33; a shift by 34 divides by six.
  localparam logic [32:0] H6_RECIP = 33'h0_AAAA_AAAB;

  // Last micro-op index of a stage and last stage of a step.
  localparam logic [3:0] UOP_LAST   = 4'd13;
  localparam logic [1:0] STAGE_LAST = 2'd3;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL
  } op_e;

  // Operand and destination selects of the register file.
  typedef enum logic [4:0] {
    R_P0, R_P1, R_P2,
    R_Y0, R_Y1, R_Y2,
    R_D0, R_D1, R_D2,
    R_T0, R_T1, R_T2,
    R_SIG, R_BET, R_RHO,
    R_HH, R_HF, R_H6,
    R_S0, R_S1, R_S2,
    R_ZERO
  } reg_e;

  typedef struct packed {
    op_e  op;
    reg_e a;
    reg_e b;
    reg_e dst;
  } uop_t;

  // Sequencer to datapath control.
  typedef struct packed {
    logic       busy;
    logic       run;
    logic [1:0] stage;
    logic [3:0] idx;
    logic       done;
  } seq_ctl_t;

  // One derivative evaluation (uops 0..7) at the trial state, then either
  // the next trial state or, in the last stage, the state update (8..13).
  function automatic uop_t lrk_ucode(input logic [1:0] stage, input logic [3:0] idx);
    uop_t u;
    reg_e hx;
    logic fin;
    u   = '{op: OP_ADD, a: R_ZERO, b: R_ZERO, dst: R_ZERO};
    hx  = (stage == 2'd2) ? R_HF : R_HH;
    fin = (stage == STAGE_LAST);
    case (idx)
      4'd0:  u = '{op: OP_SUB, a: R_Y1,  b: R_Y0,  dst: R_T0};
      4'd1:  u = '{op: OP_MUL, a: R_T0,  b: R_SIG, dst: R_D0};
      4'd2:  u = '{op: OP_SUB, a: R_RHO, b: R_Y2,  dst: R_T1};
      4'd3:  u = '{op: OP_MUL, a: R_T1,  b: R_Y0,  dst: R_T1};
      4'd4:  u = '{op: OP_SUB, a: R_T1,  b: R_Y1,  dst: R_D1};
      4'd5:  u = '{op: OP_MUL, a: R_Y0,  b: R_Y1,  dst: R_T2};
      4'd6:  u = '{op: OP_MUL, a: R_Y2,  b: R_BET, dst: R_T0};
      4'd7:  u = '{op: OP_SUB, a: R_T2,  b: R_T0,  dst: R_D2};
      4'd8:  u = '{op: OP_MUL, a: fin ? R_S0 : R_D0, b: fin ? R_H6 : hx, dst: R_T0};
      4'd9:  u = '{op: OP_ADD, a: R_P0, b: R_T0, dst: fin ? R_P0 : R_Y0};
      4'd10: u = '{op: OP_MUL, a: fin ? R_S1 : R_D1, b: fin ? R_H6 : hx, dst: R_T0};
      4'd11: u = '{op: OP_ADD, a: R_P1, b: R_T0, dst: fin ? R_P1 : R_Y1};
      4'd12: u = '{op: OP_MUL, a: fin ? R_S2 : R_D2, b: fin ? R_H6 : hx, dst: R_T0};
      4'd13: u = '{op: OP_ADD, a: R_P2, b: R_T0, dst: fin ? R_P2 : R_Y2};
      default: u = '{op: OP_ADD, a: R_ZERO, b: R_ZERO, dst: R_ZERO};
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

FILE: design/lrk_alu.sv
// Shared saturating add, subtract and rounded fixed-point multiply unit.
// Depends on lrk_pkg for the operation codes.
`timescale 1ns / 1ps
`default_nettype none

module lrk_alu #(
  parameter int FRAC_BITS = 24
) (
  input  lrk_pkg::op_e       op_i,
  input  logic signed [34:0] a_i,
  input  logic signed [31:0] b_i,
  output logic signed [31:0] res_o,
  output logic               sat_o
);
  import lrk_pkg::*;

  localparam logic signed [66:0] S32_MAX = 67'sd2147483647;
  localparam logic signed [66:0] S32_MIN = -S32_MAX - 67'sd1;
  localparam logic signed [66:0] RND     = 67'sd1 <<< (FRAC_BITS - 1);

  logic signed [66:0] prod, shf, val;

  // Product rounded to nearest, ties up: add half an LSB, then floor.
  assign prod = 67'(a_i) * 67'(b_i);
  assign shf  = (prod + RND) >>> FRAC_BITS;

  always_comb begin
    unique case (op_i)
      OP_ADD:  val = 67'(a_i) + 67'(b_i);
      OP_SUB:  val = 67'(a_i) - 67'(b_i);
      OP_MUL:  val = shf;
      default: val = '0;
    endcase
  end

  // Saturate to the signed 32-bit range.
  always_comb begin
    sat_o = 1'b0;
    res_o = val[31:0];
    if (val > S32_MAX) begin
      sat_o = 1'b1;
      res_o = 32'sh7FFF_FFFF;
    end else if (val < S32_MIN) begin
      sat_o = 1'b1;
      res_o = 32'sh8000_0000;
    end
  end

endmodule

`default_nettype wire

FILE: design/lrk_seq.sv
// Sequencer: walks four stages of fourteen micro-ops for a step word.
// Depends on lrk_pkg for the control struct.
`timescale 1ns / 1ps
`default_nettype none

module lrk_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_step_i,
  input  logic              start_load_i,
  input  logic              out_free_i,
  output lrk_pkg::seq_ctl_t ctl_o
);
  import lrk_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_FIN  = 3'b100
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] stage_q, stage_d;
  logic [3:0] idx_q, idx_d;

  // Next state and micro-op counters.
  always_comb begin
    state_d = state_q;
    stage_d = stage_q;
    idx_d   = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        stage_d = '0;
        idx_d   = '0;
        if (start_step_i) begin
          state_d = ST_RUN;
        end else if (start_load_i) begin
          state_d = ST_FIN;
        end
      end
      ST_RUN: begin
        if (idx_q == UOP_LAST) begin
          idx_d = '0;
          if (stage_q == STAGE_LAST) begin
            state_d = ST_FIN;
          end else begin
            stage_d = stage_q + 2'd1;
          end
        end else begin
          idx_d = idx_q + 4'd1;
        end
      end
      ST_FIN: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      stage_q <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      stage_q <= stage_d;
      idx_q   <= idx_d;
    end
  end

  assign ctl_o.busy  = (state_q != ST_IDLE);
  assign ctl_o.run   = (state_q == ST_RUN);
  assign ctl_o.stage = stage_q;
  assign ctl_o.idx   = idx_q;
  assign ctl_o.done  = (state_q == ST_FIN) && out_free_i;

endmodule

`default_nettype wire

FILE: design/lorenz_rk4_integrator.sv
// Lorenz RK4 integrator, fixed point. A step word runs 56 micro-ops (four stages
// of 14) through the single shared add, subtract and multiply unit, then its
// result is loaded into the output register once that register is free. A load
// word's result goes to the output register once it is free. One word is in
// work at a time, so no new word is taken until the last result is loaded.
// Reset (asynchronous, active low) clears state, time and step count and
// sets the coefficient registers to sigma 10, beta 8/3, rho 28, h 0.025.
`timescale 1ns / 1ps
`default_nettype none

module lorenz_rk4_integrator #(
  parameter int FRAC_BITS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lrk_pkg::in_word_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lrk_pkg::out_word_t out_data_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [47:0]        cfg_wdata_i
);
  import lrk_pkg::*;

  localparam logic [31:0] SIGMA_RST = 32'(64'd10 << FRAC_BITS);
  localparam logic [31:0] RHO_RST   = 32'(64'd28 << FRAC_BITS);
  localparam logic [31:0] BETA_RST  = 32'((((64'd16 << FRAC_BITS) / 3) + 64'd1) / 2);
  localparam logic [30:0] STEP_RST  = 31'((((64'd1 << FRAC_BITS) / 20) + 64'd1) / 2);
  localparam logic [31:0] H6_RST    = 32'((64'(STEP_RST) + 64'd3) / 6);
  localparam logic [47:0] S48_MAX   = 48'h7FFF_FFFF_FFFF;

  // Configuration registers.
  logic signed [31:0] sigma_q, beta_q, rho_q;
  logic [30:0]        step_q;
  logic [31:0]        h6_q;
  logic signed [47:0] start_q;
  logic [15:0]        runs_q;
  logic [31:0]        h6_n;
  logic [64:0]        h6_prod;

  // h/6 rounded to nearest is (h + 3) / 6, formed when h is written.
  assign h6_n    = 32'(cfg_wdata_i[30:0]) + 32'd3;
  assign h6_prod = 65'(h6_n) * 65'(H6_RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sigma_q <= SIGMA_RST;
      beta_q  <= BETA_RST;
      rho_q   <= RHO_RST;
      step_q  <= STEP_RST;
      h6_q    <= H6_RST;
      start_q <= '0;
      runs_q  <= 16'd4000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SIGMA: sigma_q <= cfg_wdata_i[31:0];
        CFG_BETA:  beta_q  <= cfg_wdata_i[31:0];
        CFG_RHO:   rho_q   <= cfg_wdata_i[31:0];
        CFG_STEP: begin
          step_q <= cfg_wdata_i[30:0];
          h6_q   <= 32'(h6_prod >> 34);
        end
        CFG_START: start_q <= cfg_wdata_i;
        CFG_RUNS:  runs_q  <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // Sequencer.
  seq_ctl_t ctl;
  logic     in_fire, out_free;
  logic     out_valid_q;

  assign in_stall_o = ctl.busy;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  lrk_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_step_i (in_fire && (in_data_i.req_type != REQ_LOAD)),
    .start_load_i (in_fire && (in_data_i.req_type == REQ_LOAD)),
    .out_free_i   (out_free),
    .ctl_o        (ctl)
  );

  // Register file of the step.
  logic signed [31:0] pos_q [3];
  logic signed [31:0] yt_q  [3];
  logic signed [31:0] d_q   [3];
  logic signed [31:0] t_q   [3];
  logic signed [34:0] s_q   [3];
  logic signed [47:0] time_q;
  logic [15:0]        cnt_q;
  logic               last_q, small_q, ovf_q;

  uop_t               uop;
  logic signed [34:0] op_a;
  logic signed [31:0] op_b, res;
  logic               res_sat;

  assign uop = lrk_ucode(ctl.stage, ctl.idx);

  // Operand selection.
  always_comb begin
    case (uop.a)
      R_P0:    op_a = 35'(pos_q[0]);
      R_P1:    op_a = 35'(pos_q[1]);
      R_P2:    op_a = 35'(pos_q[2]);
      R_Y0:    op_a = 35'(yt_q[0]);
      R_Y1:    op_a = 35'(yt_q[1]);
      R_Y2:    op_a = 35'(yt_q[2]);
      R_D0:    op_a = 35'(d_q[0]);
      R_D1:    op_a = 35'(d_q[1]);
      R_D2:    op_a = 35'(d_q[2]);
      R_T0:    op_a = 35'(t_q[0]);
      R_T1:    op_a = 35'(t_q[1]);
      R_T2:    op_a = 35'(t_q[2]);
      R_RHO:   op_a = 35'(rho_q);
      R_S0:    op_a = s_q[0];
      R_S1:    op_a = s_q[1];
      R_S2:    op_a = s_q[2];
      default: op_a = '0;
    endcase
    case (uop.b)
      R_Y0:    op_b = yt_q[0];
      R_Y1:    op_b = yt_q[1];
      R_Y2:    op_b = yt_q[2];
      R_T0:    op_b = t_q[0];
      R_SIG:   op_b = sigma_q;
      R_BET:   op_b = beta_q;
      R_HH:    op_b = $signed({2'b00, step_q[30:1]});
      R_HF:    op_b = $signed({1'b0, step_q});
      R_H6:    op_b = $signed(h6_q);
      default: op_b = '0;
    endcase
  end

  lrk_alu #(
    .FRAC_BITS (FRAC_BITS)
  ) u_alu (
    .op_i  (uop.op),
    .a_i   (op_a),
    .b_i   (op_b),
    .res_o (res),
    .sat_o (res_sat)
  );

  // Time advance, saturating upward only since h is never negative.
  logic signed [48:0] time_sum;
  logic [15:0]        cnt_inc;
  assign time_sum = 49'(time_q) + 49'({1'b0, step_q});
  assign cnt_inc  = cnt_q + 16'd1;

  // Derivative weight in the RK4 sum: 1 for k1 and k4, 2 for k2 and k3.
  logic signed [34:0] k_term;
  assign k_term = ((ctl.stage == 2'd1) || (ctl.stage == 2'd2)) ? (35'(res) <<< 1) : 35'(res);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        pos_q[i] <= '0;
        yt_q[i]  <= '0;
        d_q[i]   <= '0;
        t_q[i]   <= '0;
        s_q[i]   <= '0;
      end
      time_q  <= '0;
      cnt_q   <= '0;
      last_q  <= 1'b0;
      small_q <= 1'b0;
      ovf_q   <= 1'b0;
    end else if (in_fire) begin
      if (in_data_i.req_type == REQ_LOAD) begin
        pos_q[0] <= in_data_i.init_x;
        pos_q[1] <= in_data_i.init_y;
        pos_q[2] <= in_data_i.init_z;
        time_q   <= start_q;
        cnt_q    <= '0;
        last_q   <= 1'b0;
        small_q  <= 1'b0;
        ovf_q    <= 1'b0;
      end else begin
        for (int i = 0; i < 3; i++) begin
          yt_q[i] <= pos_q[i];
        end
        if (time_sum[48] != time_sum[47]) begin
          time_q <= S48_MAX;
          ovf_q  <= 1'b1;
        end else begin
          time_q <= time_sum[47:0];
          ovf_q  <= 1'b0;
        end
        cnt_q   <= cnt_inc;
        last_q  <= (cnt_inc == runs_q);
        small_q <= (step_q == '0);
      end
    end else if (ctl.run) begin
      ovf_q <= ovf_q | res_sat;
      case (uop.dst)
        R_P0: pos_q[0] <= res;
        R_P1: pos_q[1] <= res;
        R_P2: pos_q[2] <= res;
        R_Y0: yt_q[0]  <= res;
        R_Y1: yt_q[1]  <= res;
        R_Y2: yt_q[2]  <= res;
        R_D0: d_q[0]   <= res;
        R_D1: d_q[1]   <= res;
        R_D2: d_q[2]   <= res;
        R_T0: t_q[0]   <= res;
        R_T1: t_q[1]   <= res;
        R_T2: t_q[2]   <= res;
        default: ;
      endcase
      // Running sum k1 + 2k2 + 2k3 + k4 at full width.
      case (uop.dst)
        R_D0: s_q[0] <= (ctl.stage == 2'd0) ? k_term : s_q[0] + k_term;
        R_D1: s_q[1] <= (ctl.stage == 2'd0) ? k_term : s_q[1] + k_term;
        R_D2: s_q[2] <= (ctl.stage == 2'd0) ? k_term : s_q[2] + k_term;
        default: ;
      endcase
    end
  end

  // Output register.
  out_word_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.done) begin
      out_q.out_x          <= pos_q[0];
      out_q.out_y          <= pos_q[1];
      out_q.out_z          <= pos_q[2];
      out_q.time_now       <= time_q;
      out_q.step_index     <= cnt_q;
      out_q.last_step      <= last_q;
      out_q.step_too_small <= small_q;
      out_q.overflow       <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Accepting a word always makes the block busy on the next cycle.
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> in_stall_o)
    else $error("block not busy after accepting a word");

  // A step never moves time backward.
  a_time_monotonic : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_data_i.req_type != REQ_LOAD)) |=> (time_q >= $past(time_q)))
    else $error("time decreased on a step");

  // A new result is only loaded when the output register is free.
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.done |-> (!out_valid_q || !out_stall_i))
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire

FILE: sim/lorenz_rk4_integrator_tb.sv
// Self-checking testbench of the Lorenz RK4 integrator: a fixed-point predictor
// and a small scoreboard check every result word. Depends on lrk_pkg and the block.
`timescale 1ns / 1ps

module lorenz_rk4_integrator_tb;
  import lrk_pkg::*;

  localparam int FB = 24;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam longint S48_MAX = 64'sd140737488355327;
  localparam longint S48_MIN = -64'sd140737488355328;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_word_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_word_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = CFG_SIGMA;
  logic [47:0] cfg_wdata_i = '0;

  bit hold_off = 1'b0;

  lorenz_rk4_integrator DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  // Predictor state and configuration copy.
  longint sigma_q, beta_q, rho_q, hstep, t_start, n_run;
  longint px, py, pz, t_acc, n_step;
  bit sat_seen;

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v > hi) begin sat_seen = 1'b1; return hi; end
    if (v < lo) begin sat_seen = 1'b1; return lo; end
    return v;
  endfunction

  // Rounded product, ties toward plus infinity; >>> floors.
  function automatic longint qmul(longint a, longint b);
    longint p;
    p = a * b + (64'sd1 <<< (FB - 1));
    return clamp(p >>> FB, S32_MIN, S32_MAX);
  endfunction

  function automatic longint qadd(longint a, longint b);
    return clamp(a + b, S32_MIN, S32_MAX);
  endfunction

  function automatic longint qsub(longint a, longint b);
    return clamp(a - b, S32_MIN, S32_MAX);
  endfunction

  task automatic lorenz_deriv(input longint v[3], output longint d[3]);
    d[0] = qmul(sigma_q, qsub(v[1], v[0]));
    d[1] = qsub(qmul(v[0], qsub(rho_q, v[2])), v[1]);
    d[2] = qsub(qmul(v[0], v[1]), qmul(beta_q, v[2]));
  endtask

  // Works out the result word that one input word causes.
  task automatic predict_word(input in_word_t w, output out_word_t r);
    longint hh, h6, s;
    longint p[3], k1[3], k2[3], k3[3], k4[3], yt[3];
    bit last, tiny;
    last = 0; tiny = 0; sat_seen = 0;
    if (w.req_type == REQ_LOAD) begin
      px = w.init_x; py = w.init_y; pz = w.init_z;
      t_acc = t_start; n_step = 0;
    end else begin
      hh = hstep >>> 1;
      h6 = (hstep + 3) / 6;
      p[0] = px; p[1] = py; p[2] = pz;
      lorenz_deriv(p, k1);
      for (int i = 0; i < 3; i++) yt[i] = qadd(p[i], qmul(hh, k1[i]));
      lorenz_deriv(yt, k2);
      for (int i = 0; i < 3; i++) yt[i] = qadd(p[i], qmul(hh, k2[i]));
      lorenz_deriv(yt, k3);
      for (int i = 0; i < 3; i++) yt[i] = qadd(p[i], qmul(hstep, k3[i]));
      lorenz_deriv(yt, k4);
      for (int i = 0; i < 3; i++) begin
        s = k1[i] + k4[i] + 2 * (k2[i] + k3[i]);
        p[i] = qadd(p[i], qmul(h6, s));
      end
      px = p[0]; py = p[1]; pz = p[2];
      tiny = (hstep == 0);
      t_acc = clamp(t_acc + hstep, S48_MIN, S48_MAX);
      n_step = (n_step + 1) & 16'hFFFF;
      last = (n_step == n_run);
    end
    r.out_x = px[31:0]; r.out_y = py[31:0]; r.out_z = pz[31:0];
    r.time_now = t_acc[47:0]; r.step_index = n_step[15:0];
    r.last_step = last; r.step_too_small = tiny; r.overflow = sat_seen;
  endtask

  // Scoreboard of expected result words.
  class lorenz_scoreboard;
    out_word_t pending[$];
    int errors = 0;

    function void note_input(out_word_t r);
      pending.push_back(r);
    endfunction

    function void check_result(out_word_t a);
      out_word_t e;
      if (pending.size() == 0) begin
        $error("unexpected result word %h", a);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.out_x !== e.out_x) begin $error("out_x exp %h got %h", e.out_x, a.out_x); errors++; end
      if (a.out_y !== e.out_y) begin $error("out_y exp %h got %h", e.out_y, a.out_y); errors++; end
      if (a.out_z !== e.out_z) begin $error("out_z exp %h got %h", e.out_z, a.out_z); errors++; end
      if (a.time_now !== e.time_now) begin
        $error("time_now exp %h got %h", e.time_now, a.time_now); errors++;
      end
      if (a.step_index !== e.step_index) begin
        $error("step_index exp %0d got %0d", e.step_index, a.step_index); errors++;
      end
      if (a.last_step !== e.last_step) begin
        $error("last_step exp %b got %b", e.last_step, a.last_step); errors++;
      end
      if (a.step_too_small !== e.step_too_small) begin
        $error("step_too_small exp %b got %b", e.step_too_small, a.step_too_small); errors++;
      end
      if (a.overflow !== e.overflow) begin
        $error("overflow exp %b got %b", e.overflow, a.overflow); errors++;
      end
    endfunction
  endclass

  lorenz_scoreboard sb = new();

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  // Sends one word and feeds the predictor when it is accepted. Valid drops
  // afterward, while the block is still busy.
  task automatic send_word(input in_word_t w);
    out_word_t r;
    in_valid_i <= 1'b1;
    in_data_i <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_word(w, r);
    sb.note_input(r);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_with_gap(input in_word_t w);
    int g;
    send_word(w);
    g = gap_len();
    repeat (g) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input longint v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= v[47:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_SIGMA: sigma_q = longint'($signed(v[31:0]));
      CFG_BETA:  beta_q = longint'($signed(v[31:0]));
      CFG_RHO:   rho_q = longint'($signed(v[31:0]));
      CFG_STEP:  hstep = v & 64'h7FFF_FFFF;
      CFG_START: t_start = longint'($signed(v[47:0]));
      CFG_RUNS:  n_run = v & 64'hFFFF;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Waits until all expected words are back plus the block's step latency.
  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (70) @(posedge clk_i);
  endtask

  function automatic in_word_t mk(input logic kind, input longint x, input longint y,
                                  input longint z);
    in_word_t w;
    w.req_type = kind;
    w.init_x = x[31:0]; w.init_y = y[31:0]; w.init_z = z[31:0];
    return w;
  endfunction

  function automatic in_word_t rand_load();
    in_word_t w;
    w.req_type = REQ_LOAD;
    if ($urandom_range(0, 3) == 0) begin
      w.init_x = $urandom(); w.init_y = $urandom(); w.init_z = $urandom();
    end else begin
      w.init_x = $signed($urandom_range(0, 32'h3FFF_FFFF)) - 32'sh2000_0000;
      w.init_y = $signed($urandom_range(0, 32'h3FFF_FFFF)) - 32'sh2000_0000;
      w.init_z = $urandom_range(0, 32'h3200_0000);
    end
    return w;
  endfunction

  // One configuration phase with random or chosen coefficients.
  task automatic random_setting(input int kind);
    longint h;
    case (kind)
      0: begin
        write_reg(CFG_SIGMA, 167772160); write_reg(CFG_BETA, 44739243);
        write_reg(CFG_RHO, 469762048);
      end
      1: begin
        write_reg(CFG_SIGMA, 64'sh7FFF_FFFF); write_reg(CFG_BETA, -64'sh8000_0000);
        write_reg(CFG_RHO, 64'sh7FFF_FFFF);
      end
      default: begin
        write_reg(CFG_SIGMA, longint'($signed($urandom())));
        write_reg(CFG_BETA, longint'($signed($urandom())));
        write_reg(CFG_RHO, longint'($signed($urandom())));
      end
    endcase
    h = (kind == 1) ? 64'h7FFF_FFFF : (($urandom_range(0, 5) == 0) ? 0 :
        $urandom_range(1, 32'h0100_0000));
    write_reg(CFG_STEP, h);
    write_reg(CFG_START, {$urandom(), $urandom()});
    write_reg(CFG_RUNS, $urandom_range(0, 40));
  endtask

  // Receiver: random stalls, one long hold-off on request.
  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        out_stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
      g = gap_len();
      if (g == 0) begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b1;
        repeat (g) @(posedge clk_i);
      end
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  initial begin
    #60_000_000;
    $display("lorenz_rk4_integrator test failed");
    $finish;
  end

  initial begin
    in_word_t w;
    int sent;
    sigma_q = 167772160; beta_q = 44739243; rho_q = 469762048;
    hstep = 419430; t_start = 0; n_run = 4000;
    px = 0; py = 0; pz = 0; t_acc = 0; n_step = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: steps from reset state, loads at field extremes, default setting.
    send_word(mk(REQ_STEP, 0, 0, 0));
    send_word(mk(REQ_LOAD, 1 << 24, 1 << 24, 1 << 24));
    repeat (3) send_word(mk(REQ_STEP, 0, 0, 0));
    send_word(mk(REQ_LOAD, 64'sh7FFF_FFFF, -64'sh8000_0000, 64'sh7FFF_FFFF));
    repeat (2) send_word(mk(REQ_STEP, -1, -1, -1));
    send_word(mk(REQ_LOAD, -64'sh8000_0000, 64'sh7FFF_FFFF, -64'sh8000_0000));
    send_word(mk(REQ_STEP, 64'hFFFF_FFFF, 64'hFFFF_FFFF, 64'hFFFF_FFFF));
    drain();

    // Zero step, run length 1 and 0, time near saturation.
    write_reg(CFG_STEP, 0);
    write_reg(CFG_RUNS, 1);
    write_reg(CFG_START, 64'sh7FFF_FFFF_FFFF);
    send_word(mk(REQ_LOAD, 5 << 24, 3 << 24, 7 << 24));
    repeat (2) send_word(mk(REQ_STEP, 0, 0, 0));
    drain();
    write_reg(CFG_STEP, 64'h7FFF_FFFF);
    write_reg(CFG_START, 64'sh7FFF_FFFF_0000);
    write_reg(CFG_RUNS, 0);
    send_word(mk(REQ_LOAD, 1 << 20, 1 << 20, 1 << 20));
    repeat (3) send_word(mk(REQ_STEP, 0, 0, 0));
    drain();
    write_reg(CFG_START, -64'sh8000_0000_0000);
    write_reg(CFG_STEP, 1);
    send_word(mk(REQ_LOAD, 0, 0, 0));
    send_word(mk(REQ_STEP, 0, 0, 0));
    drain();

    // Long run with tiny h and run_steps at its maximum.
    random_setting(0);
    write_reg(CFG_STEP, 1);
    write_reg(CFG_RUNS, 65535);
    send_word(mk(REQ_LOAD, 1 << 24, 0, 0));
    for (int i = 0; i < 100; i++) send_word(mk(REQ_STEP, 0, 0, 0));
    drain();

    // Back-pressure: the receiver holds off while words keep coming.
    hold_off = 1'b1;
    for (int i = 0; i < 20; i++) begin
      send_word(mk(i % 5 == 0 ? REQ_LOAD : REQ_STEP, i << 22, 1 << 24, 0));
    end
    drain();

    // Random phases: mostly load-then-run sequences.
    sent = 0;
    while (sent < 1800) begin
      random_setting($urandom_range(0, 5));
      for (int k = 0; k < 100; k++) begin
        if (k == 0 || $urandom_range(0, 29) == 0) w = rand_load();
        else begin
          w.req_type = REQ_STEP;
          w.init_x = $urandom(); w.init_y = $urandom(); w.init_z = $urandom();
        end
        send_with_gap(w);
        sent++;
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("lorenz_rk4_integrator test passed");
    end else begin
      $display("lorenz_rk4_integrator test failed");
    end
    $finish;
  end

endmodule
